// File: hw/rtl/bth_pkg.sv
// -----------------------------------------------------------------------------
// bth_pkg
// shared types and constants of the boundary tag heap allocator
// -----------------------------------------------------------------------------
package bth_pkg;

   localparam int HEAP_BYTES   = 1024;
   localparam int HEADER_BYTES = 32;
   localparam int TAG_BYTES    = 16;
   localparam int GRAIN        = 16;
   localparam int SLOTS        = HEAP_BYTES / GRAIN;

   localparam logic [6:0]  NIL          = 7'(SLOTS);
   localparam logic [10:0] INIT_PAYLOAD = 11'(HEAP_BYTES - HEADER_BYTES - TAG_BYTES);
   localparam logic [11:0] OVERHEAD     = 12'(HEADER_BYTES + TAG_BYTES);
   localparam logic [6:0]  OVH_SLOTS    = 7'((HEADER_BYTES + TAG_BYTES) / GRAIN);
   localparam logic [12:0] SPLIT_MIN    = 13'(HEADER_BYTES + TAG_BYTES + GRAIN);

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;

   typedef struct packed {
      logic [5:0]  raddr;
      logic        size_we;
      logic [5:0]  size_wa;
      logic        size_wfree;
      logic [10:0] size_wd;
      logic        next_we;
      logic [5:0]  next_wa;
      logic [6:0]  next_wd;
      logic        prev_we;
      logic [5:0]  prev_wa;
      logic [6:0]  prev_wd;
   } bth_mem_req_type;

   typedef struct packed {
      logic        is_free;
      logic [10:0] size;
      logic [6:0]  next;
      logic [6:0]  prev;
   } bth_mem_rsp_type;

endpackage

// File: hw/rtl/boundary_tag_heap_allocator_core.sv
// -----------------------------------------------------------------------------
// boundary_tag_heap_allocator_core
// heap allocator with boundary tags and an ordered explicit free list
// -----------------------------------------------------------------------------
// channel  | dir | handshake               | payload
// req      | in  | req_tvalid / req_tready | tdata request_bytes, release_offset; tuser opcode
// rsp      | out | rsp_tvalid / rsp_tready | tdata status, granted_offset
// csr      | in  | psel / penable / pready | fit_policy at address 0
//
// one item at a time; an allocate walks the free list entries, a free walks the
// blocks from slot zero up to the one released, merges it with free neighbours
// and walks the free list to reach the tail, where the merged block is appended.
// the tag and link memories share a single read address, so each step reads one entry.
// reset is immediate: no clearing pass, slot zero reads as the whole heap.
// a stalled result waits in the output register; the next request is still taken, and its result waits until it leaves.
// -----------------------------------------------------------------------------
module boundary_tag_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // request_bytes[10:0], release_offset[20:11], zeros
   input  logic [0:0]  req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], granted_offset[11:2], zeros
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bth_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_A_WALK   = 4'd1;
   localparam logic [3:0] S_A_PICK   = 4'd2;
   localparam logic [3:0] S_A_W1     = 4'd3;
   localparam logic [3:0] S_A_W2     = 4'd4;
   localparam logic [3:0] S_F_WALK   = 4'd5;
   localparam logic [3:0] S_F_RDATA  = 4'd6;
   localparam logic [3:0] S_F_DEC    = 4'd7;
   localparam logic [3:0] S_R_RD     = 4'd8;
   localparam logic [3:0] S_R_WR     = 4'd9;
   localparam logic [3:0] S_AP_START = 4'd10;
   localparam logic [3:0] S_AP_WALK  = 4'd11;
   localparam logic [3:0] S_AP_FIN   = 4'd12;
   localparam logic [3:0] S_OUT      = 4'd13;

   bth_mem_req_type mem_req;
   bth_mem_rsp_type mem_rsp;

   bth_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   logic [3:0]  state_ff, state_in;
   logic [6:0]  head_ff, head_in;
   logic [1:0]  policy_ff, policy_in;
   logic [6:0]  cur_ff, cur_in;
   logic [11:0] need_ff, need_in;
   logic [6:0]  pick_ff, pick_in;
   logic [10:0] pick_size_ff, pick_size_in;
   logic [6:0]  pick_next_ff, pick_next_in;
   logic [6:0]  pick_prev_ff, pick_prev_in;
   logic        found_ff, found_in;
   logic [5:0]  t_ff, t_in;
   logic [10:0] t_size_ff, t_size_in;
   logic [6:0]  left_ff, left_in;
   logic        left_free_ff, left_free_in;
   logic [10:0] left_size_ff, left_size_in;
   logic [6:0]  right_ff, right_in;
   logic        right_free_ff, right_free_in;
   logic [10:0] right_size_ff, right_size_in;
   logic [6:0]  rem_ff, rem_in;
   logic        pend_r_ff, pend_r_in;
   logic [5:0]  start_ff, start_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [9:0]  res_offset_ff, res_offset_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [9:0]  rsp_offset_ff, rsp_offset_in;

   logic        req_fire;
   logic        csr_write;
   logic [10:0] req_bytes;
   logic [9:0]  rel_off;
   logic [9:0]  rel_rel;
   logic        fits;
   logic        better;
   logic [7:0]  split_slot;
   logic        do_split;
   logic [12:0] fit_floor;
   logic [10:0] rest;
   logic [6:0]  next_phys;
   logic        lf;
   logic        rf;
   logic [11:0] merged;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_bytes  = req_tdata[10:0];
   assign rel_off    = req_tdata[20:11];
   assign rel_rel    = rel_off - 10'(HEADER_BYTES);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {30'd0, policy_ff} : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_offset_ff, rsp_status_ff};

   assign fits   = {1'b0, mem_rsp.size} >= need_ff;
   assign better = (policy_ff == FIT_BEST) ? (mem_rsp.size < pick_size_ff)
                                           : (mem_rsp.size > pick_size_ff);

   // split point of the chosen block and the leftover payload
   assign fit_floor  = {1'b0, need_ff} + SPLIT_MIN;
   assign split_slot = {1'b0, pick_ff} + {1'b0, OVH_SLOTS} + {1'b0, need_ff[10:4]};
   assign do_split   = ({2'b0, pick_size_ff} >= fit_floor) && (split_slot < {1'b0, NIL});
   assign rest       = 11'({1'b0, pick_size_ff} - need_ff - OVERHEAD);

   assign next_phys = cur_ff + OVH_SLOTS + mem_rsp.size[10:4];

   assign lf = (left_ff < NIL) && left_free_ff;
   assign rf = (right_ff < NIL) && right_free_ff;
   assign merged = {1'b0, t_size_ff}
                 + (lf ? ({1'b0, left_size_ff} + OVERHEAD) : 12'd0)
                 + (rf ? ({1'b0, right_size_ff} + OVERHEAD) : 12'd0);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      policy_in     = policy_ff;
      cur_in        = cur_ff;
      need_in       = need_ff;
      pick_in       = pick_ff;
      pick_size_in  = pick_size_ff;
      pick_next_in  = pick_next_ff;
      pick_prev_in  = pick_prev_ff;
      found_in      = found_ff;
      t_in          = t_ff;
      t_size_in     = t_size_ff;
      left_in       = left_ff;
      left_free_in  = left_free_ff;
      left_size_in  = left_size_ff;
      right_in      = right_ff;
      right_free_in = right_free_ff;
      right_size_in = right_size_ff;
      rem_in        = rem_ff;
      pend_r_in     = pend_r_ff;
      start_in      = start_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      mem_req       = '0;

      if (csr_write && csr_paddr[2] == 1'b0) begin
         policy_in = csr_pwdata[1:0];
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_offset_in = 10'd0;
               res_status_in = ST_DONE;
               if (req_tuser[0] == OP_ALLOC) begin
                  need_in  = ({1'b0, req_bytes} + 12'd15) & 12'hFF0;
                  pick_in  = NIL;
                  found_in = 1'b0;
                  cur_in   = head_ff;
                  mem_req.raddr = head_ff[5:0];
                  state_in = (head_ff < NIL) ? S_A_WALK : S_A_PICK;
               end else if (rel_off < 10'(HEADER_BYTES) || rel_rel[3:0] != 4'd0) begin
                  res_status_in = ST_IGNORED;
                  state_in      = S_OUT;
               end else begin
                  t_in     = rel_rel[9:4];
                  cur_in   = 7'd0;
                  left_in  = NIL;
                  mem_req.raddr = 6'd0;
                  state_in = S_F_WALK;
               end
            end
         end

         S_A_WALK: begin
            if (fits && (policy_ff == FIT_FIRST || !found_ff || better)) begin
               pick_in      = cur_ff;
               pick_size_in = mem_rsp.size;
               pick_next_in = mem_rsp.next;
               pick_prev_in = mem_rsp.prev;
               found_in     = 1'b1;
            end
            if (fits && policy_ff == FIT_FIRST) begin
               state_in = S_A_PICK;
            end else if (mem_rsp.next < NIL) begin
               cur_in        = mem_rsp.next;
               mem_req.raddr = mem_rsp.next[5:0];
            end else begin
               state_in = S_A_PICK;
            end
         end

         S_A_PICK: begin
            if (pick_ff >= NIL) begin
               res_status_in = ST_NOFIT;
               state_in      = S_OUT;
            end else begin
               res_offset_in = 10'({pick_ff[5:0], 4'd0}) + 10'(HEADER_BYTES);
               if (do_split) begin
                  state_in = S_A_W1;
               end else begin
                  // unlink the whole block
                  mem_req.size_we    = 1'b1;
                  mem_req.size_wa    = pick_ff[5:0];
                  mem_req.size_wfree = 1'b0;
                  mem_req.size_wd    = pick_size_ff;
                  if (pick_prev_ff < NIL) begin
                     mem_req.next_we = 1'b1;
                     mem_req.next_wa = pick_prev_ff[5:0];
                     mem_req.next_wd = pick_next_ff;
                  end else begin
                     head_in = pick_next_ff;
                  end
                  if (pick_next_ff < NIL) begin
                     mem_req.prev_we = 1'b1;
                     mem_req.prev_wa = pick_next_ff[5:0];
                     mem_req.prev_wd = pick_prev_ff;
                  end
                  state_in = S_OUT;
               end
            end
         end

         S_A_W1: begin
            mem_req.size_we    = 1'b1;
            mem_req.size_wa    = split_slot[5:0];
            mem_req.size_wfree = 1'b1;
            mem_req.size_wd    = rest;
            mem_req.next_we    = 1'b1;
            mem_req.next_wa    = split_slot[5:0];
            mem_req.next_wd    = pick_next_ff;
            mem_req.prev_we    = 1'b1;
            mem_req.prev_wa    = split_slot[5:0];
            mem_req.prev_wd    = pick_prev_ff;
            state_in           = S_A_W2;
         end

         S_A_W2: begin
            // remainder takes the chosen block's place in the list
            mem_req.size_we    = 1'b1;
            mem_req.size_wa    = pick_ff[5:0];
            mem_req.size_wfree = 1'b0;
            mem_req.size_wd    = need_ff[10:0];
            if (pick_prev_ff < NIL) begin
               mem_req.next_we = 1'b1;
               mem_req.next_wa = pick_prev_ff[5:0];
               mem_req.next_wd = split_slot[6:0];
            end else begin
               head_in = split_slot[6:0];
            end
            if (pick_next_ff < NIL) begin
               mem_req.prev_we = 1'b1;
               mem_req.prev_wa = pick_next_ff[5:0];
               mem_req.prev_wd = split_slot[6:0];
            end
            state_in = S_OUT;
         end

         S_F_WALK: begin
            if (cur_ff[5:0] == t_ff && cur_ff < NIL) begin
               if (mem_rsp.is_free) begin
                  res_status_in = ST_IGNORED;
                  state_in      = S_OUT;
               end else begin
                  t_size_in = mem_rsp.size;
                  right_in  = next_phys;
                  if (next_phys < NIL) begin
                     mem_req.raddr = next_phys[5:0];
                     state_in      = S_F_RDATA;
                  end else begin
                     right_in      = NIL;
                     state_in      = S_F_DEC;
                  end
               end
            end else begin
               left_in      = cur_ff;
               left_free_in = mem_rsp.is_free;
               left_size_in = mem_rsp.size;
               cur_in       = next_phys;
               if (next_phys < NIL) begin
                  mem_req.raddr = next_phys[5:0];
               end else begin
                  res_status_in = ST_IGNORED;
                  state_in      = S_OUT;
               end
            end
         end

         S_F_RDATA: begin
            right_free_in = mem_rsp.is_free;
            right_size_in = mem_rsp.size;
            state_in      = S_F_DEC;
         end

         S_F_DEC: begin
            start_in           = lf ? left_ff[5:0] : t_ff;
            mem_req.size_we    = 1'b1;
            mem_req.size_wa    = lf ? left_ff[5:0] : t_ff;
            mem_req.size_wfree = 1'b1;
            mem_req.size_wd    = merged[10:0];
            if (lf) begin
               rem_in    = left_ff;
               pend_r_in = rf;
               state_in  = S_R_RD;
            end else if (rf) begin
               rem_in    = right_ff;
               pend_r_in = 1'b0;
               state_in  = S_R_RD;
            end else begin
               state_in  = S_AP_START;
            end
         end

         S_R_RD: begin
            mem_req.raddr = rem_ff[5:0];
            state_in      = S_R_WR;
         end

         S_R_WR: begin
            if (mem_rsp.prev < NIL) begin
               mem_req.next_we = 1'b1;
               mem_req.next_wa = mem_rsp.prev[5:0];
               mem_req.next_wd = mem_rsp.next;
            end else begin
               head_in = mem_rsp.next;
            end
            if (mem_rsp.next < NIL) begin
               mem_req.prev_we = 1'b1;
               mem_req.prev_wa = mem_rsp.next[5:0];
               mem_req.prev_wd = mem_rsp.prev;
            end
            if (pend_r_ff) begin
               rem_in    = right_ff;
               pend_r_in = 1'b0;
               state_in  = S_R_RD;
            end else begin
               state_in  = S_AP_START;
            end
         end

         S_AP_START: begin
            if (head_ff < NIL) begin
               cur_in        = head_ff;
               mem_req.raddr = head_ff[5:0];
               state_in      = S_AP_WALK;
            end else begin
               head_in         = {1'b0, start_ff};
               mem_req.next_we = 1'b1;
               mem_req.next_wa = start_ff;
               mem_req.next_wd = NIL;
               mem_req.prev_we = 1'b1;
               mem_req.prev_wa = start_ff;
               mem_req.prev_wd = NIL;
               state_in        = S_OUT;
            end
         end

         S_AP_WALK: begin
            if (mem_rsp.next < NIL) begin
               cur_in        = mem_rsp.next;
               mem_req.raddr = mem_rsp.next[5:0];
            end else begin
               mem_req.next_we = 1'b1;
               mem_req.next_wa = cur_ff[5:0];
               mem_req.next_wd = {1'b0, start_ff};
               mem_req.prev_we = 1'b1;
               mem_req.prev_wa = start_ff;
               mem_req.prev_wd = cur_ff;
               state_in        = S_AP_FIN;
            end
         end

         S_AP_FIN: begin
            mem_req.next_we = 1'b1;
            mem_req.next_wa = start_ff;
            mem_req.next_wd = NIL;
            state_in        = S_OUT;
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = res_offset_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= 7'd0;
         policy_ff    <= FIT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      need_ff       <= need_in;
      pick_ff       <= pick_in;
      pick_size_ff  <= pick_size_in;
      pick_next_ff  <= pick_next_in;
      pick_prev_ff  <= pick_prev_in;
      found_ff      <= found_in;
      t_ff          <= t_in;
      t_size_ff     <= t_size_in;
      left_ff       <= left_in;
      left_free_ff  <= left_free_in;
      left_size_ff  <= left_size_in;
      right_ff      <= right_in;
      right_free_ff <= right_free_in;
      right_size_ff <= right_size_in;
      rem_ff        <= rem_in;
      pend_r_ff     <= pend_r_in;
      start_ff      <= start_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

endmodule

// File: hw/rtl/bth_store.sv
// -----------------------------------------------------------------------------
// bth_store
// block tag memory and free list link memories, with registered read data
// -----------------------------------------------------------------------------
module bth_store (
   input  logic                     clock,
   input  logic                     reset,
   input  bth_pkg::bth_mem_req_type mem_req,
   output bth_pkg::bth_mem_rsp_type mem_rsp
);
   import bth_pkg::*;

   logic [11:0] tag_mem  [SLOTS];
   logic [6:0]  next_mem [SLOTS];
   logic [6:0]  prev_mem [SLOTS];

   logic [11:0] tag_q_ff;
   logic [6:0]  next_q_ff;
   logic [6:0]  prev_q_ff;
   logic [5:0]  raddr_ff;
   logic        slot0_written_ff;
   logic        slot0_written_in;

   always_ff @(posedge clock) begin
      if (mem_req.size_we) begin
         tag_mem[mem_req.size_wa] <= {mem_req.size_wfree, mem_req.size_wd};
      end
      if (mem_req.next_we) begin
         next_mem[mem_req.next_wa] <= mem_req.next_wd;
      end
      if (mem_req.prev_we) begin
         prev_mem[mem_req.prev_wa] <= mem_req.prev_wd;
      end
      tag_q_ff  <= tag_mem[mem_req.raddr];
      next_q_ff <= next_mem[mem_req.raddr];
      prev_q_ff <= prev_mem[mem_req.raddr];
      raddr_ff  <= mem_req.raddr;
   end

   // slot zero reads as the whole heap until its first write
   assign slot0_written_in = slot0_written_ff | (mem_req.size_we && mem_req.size_wa == 6'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_written_ff <= 1'b0;
      end else begin
         slot0_written_ff <= slot0_written_in;
      end
   end

   always_comb begin
      if (raddr_ff == 6'd0 && !slot0_written_ff) begin
         mem_rsp.is_free = 1'b1;
         mem_rsp.size    = INIT_PAYLOAD;
         mem_rsp.next    = NIL;
         mem_rsp.prev    = NIL;
      end else begin
         mem_rsp.is_free = tag_q_ff[11];
         mem_rsp.size    = tag_q_ff[10:0];
         mem_rsp.next    = next_q_ff;
         mem_rsp.prev    = prev_q_ff;
      end
   end

endmodule

// File: hw/rtl/bth_checker.sv
// -----------------------------------------------------------------------------
// bth_checker
// port level checks of the heap allocator core
// -----------------------------------------------------------------------------
module bth_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import bth_pkg::*;

   // a held result beat keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   // the core works on one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // only a completed allocate carries an offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_NOFIT || rsp_tdata[1:0] == ST_IGNORED)
         |-> rsp_tdata[11:2] == 10'd0)
      else $error("offset on a failed request");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("core not idle after reset");

endmodule

bind boundary_tag_heap_allocator_core bth_checker u_bth_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
